>>> sv/cmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cmc_pkg;

    localparam int PIX_W  = 8;
    localparam int COEF_W = 10;
    localparam int FRAC_W = 8;
    localparam int NUM_CH = 3;
    localparam int REG_W  = NUM_CH * COEF_W;
    localparam int IDX_W  = 2;
    localparam int PROD_W = COEF_W + PIX_W + 1;
    // three products plus the shifted bias, all in units of 2^-8
    localparam int SUM_W  = PROD_W + 2;
    localparam int Q_W    = SUM_W - FRAC_W;
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1 << (FRAC_W - 1));

    typedef enum logic [IDX_W-1:0] {
        REG_ROW_ONE,
        REG_ROW_TWO,
        REG_ROW_THREE,
        REG_BIAS
    } t_reg_idx;

    typedef struct packed {
        logic [REG_W-1:0] row_one;
        logic [REG_W-1:0] row_two;
        logic [REG_W-1:0] row_three;
        logic [REG_W-1:0] bias;
    } t_cfg;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic [PIX_W-1:0]         t_pix;

    // field k of a packed register, as a signed 10-bit value (Q2.8 for coefficients)
    function automatic t_coef coef_field(input logic [REG_W-1:0] r, input int k);
        logic [REG_W-1:0] s;
        s = r >> (COEF_W * k);
        return t_coef'(s[COEF_W-1:0]);
    endfunction

endpackage

`default_nettype wire

>>> sv/cmc_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module cmc_cfg_regs (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire cmc_pkg::t_reg_idx       i_cfg_idx,
    input  wire logic [cmc_pkg::REG_W-1:0] i_cfg_wdata,
    output cmc_pkg::t_cfg                o_cfg
);
    import cmc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ROW_ONE:   n_cfg.row_one   = i_cfg_wdata;
                REG_ROW_TWO:   n_cfg.row_two   = i_cfg_wdata;
                REG_ROW_THREE: n_cfg.row_three = i_cfg_wdata;
                REG_BIAS:      n_cfg.bias      = i_cfg_wdata;
                default:       n_cfg           = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

    a_row_one_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(i_cfg_we) && $past(i_cfg_idx) == REG_ROW_ONE
        |-> r_cfg.row_one == $past(i_cfg_wdata))
        else $error("row one register missed a write");

    a_bias_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(i_cfg_we) && $past(i_cfg_idx) == REG_BIAS
        |-> r_cfg.bias == $past(i_cfg_wdata) && $stable(r_cfg.row_one))
        else $error("bias write went astray");

    a_no_write_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(i_cfg_we) |-> $stable(r_cfg))
        else $error("configuration changed without a write");

endmodule

`default_nettype wire

>>> sv/cmc_channel.sv
`timescale 1ns / 1ps
`default_nettype none

module cmc_channel (
    input  wire logic [cmc_pkg::REG_W-1:0] i_row,
    input  wire cmc_pkg::t_coef            i_bias,
    input  wire cmc_pkg::t_pix             i_a,
    input  wire cmc_pkg::t_pix             i_b,
    input  wire cmc_pkg::t_pix             i_c,
    output cmc_pkg::t_pix                  o_pix
);
    import cmc_pkg::*;

    logic signed [PIX_W:0]    x    [NUM_CH];
    logic signed [PROD_W-1:0] prod [NUM_CH];
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  rnd;
    logic signed [Q_W-1:0]    q;

    always_comb begin
        x[0] = signed'({1'b0, i_a});
        x[1] = signed'({1'b0, i_b});
        x[2] = signed'({1'b0, i_c});
        for (int k = 0; k < NUM_CH; k++) begin
            prod[k] = PROD_W'(coef_field(i_row, k)) * PROD_W'(x[k]);
        end
        sum = SUM_W'(signed'({i_bias, FRAC_W'(0)}));
        for (int k = 0; k < NUM_CH; k++) begin
            sum = sum + SUM_W'(prod[k]);
        end
        // round half up, then floor by dropping the fraction bits
        rnd = sum + ROUND_HALF;
        q   = rnd[SUM_W-1:FRAC_W];
        if (q[Q_W-1]) begin
            o_pix = '0;
        end else if (|q[Q_W-2:PIX_W]) begin
            o_pix = '1;
        end else begin
            o_pix = q[PIX_W-1:0];
        end
    end

endmodule

`default_nettype wire

>>> sv/color_matrix_convert.sv
`timescale 1ns / 1ps
`default_nettype none

// Colour matrix converter: out_r = sat(round(sum_k c_rk * x_k + bias_r)), three
// output channels, coefficients signed Q2.8, biases signed 10-bit integers, pixels unsigned 8-bit.
//
// Pixel input: i_valid / o_ready with the three components and the frame-start
// and line-end flags. Pixel output: o_valid / i_ready, same shape; the flags
// travel with their pixel unchanged.
// Configuration: i_cfg_we writes i_cfg_wdata into register i_cfg_idx (row one,
// row two, row three, bias) at the clock edge. Write only with no pixel in flight.
//
// An accepted input beat reaches o_valid through one input register, then the
// products, sum, rounding and clamp, then the output register. One pixel a
// cycle is sustained while i_ready stays high; the path between the two registers
// is three 10x9 multiplies and a four-input add per channel.
// Reset (synchronous, active low) empties both stages and clears every
// configuration register to zero. If the receiver stalls, the output beat holds,
// the input register takes one more pixel and o_ready then drops until
// the output moves on.
module color_matrix_convert (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire cmc_pkg::t_reg_idx         i_cfg_idx,
    input  wire logic [cmc_pkg::REG_W-1:0] i_cfg_wdata,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire cmc_pkg::t_pix             i_chan_a_in,
    input  wire cmc_pkg::t_pix             i_chan_b_in,
    input  wire cmc_pkg::t_pix             i_chan_c_in,
    input  wire logic                      i_frame_start_in,
    input  wire logic                      i_line_end_in,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output cmc_pkg::t_pix                  o_chan_a_out,
    output cmc_pkg::t_pix                  o_chan_b_out,
    output cmc_pkg::t_pix                  o_chan_c_out,
    output logic                           o_frame_start_out,
    output logic                           o_line_end_out
);
    import cmc_pkg::*;

    t_cfg cfg;

    logic r_s1_valid;
    t_pix r_s1_a, r_s1_b, r_s1_c;
    logic r_s1_fs, r_s1_le;

    logic r_out_valid;
    t_pix r_out_a, r_out_b, r_out_c;
    logic r_out_fs, r_out_le;

    t_pix conv_a, conv_b, conv_c;
    logic in_take;
    logic s2_load;

    cmc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    cmc_channel u_ch_a (
        .i_row  (cfg.row_one),
        .i_bias (coef_field(cfg.bias, 0)),
        .i_a    (r_s1_a),
        .i_b    (r_s1_b),
        .i_c    (r_s1_c),
        .o_pix  (conv_a)
    );

    cmc_channel u_ch_b (
        .i_row  (cfg.row_two),
        .i_bias (coef_field(cfg.bias, 1)),
        .i_a    (r_s1_a),
        .i_b    (r_s1_b),
        .i_c    (r_s1_c),
        .o_pix  (conv_b)
    );

    cmc_channel u_ch_c (
        .i_row  (cfg.row_three),
        .i_bias (coef_field(cfg.bias, 2)),
        .i_a    (r_s1_a),
        .i_b    (r_s1_b),
        .i_c    (r_s1_c),
        .o_pix  (conv_c)
    );

    assign s2_load = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || s2_load;
    assign in_take = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (!r_out_valid || i_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
        if (in_take) begin
            r_s1_a  <= i_chan_a_in;
            r_s1_b  <= i_chan_b_in;
            r_s1_c  <= i_chan_c_in;
            r_s1_fs <= i_frame_start_in;
            r_s1_le <= i_line_end_in;
        end
        if (s2_load) begin
            r_out_a  <= conv_a;
            r_out_b  <= conv_b;
            r_out_c  <= conv_c;
            r_out_fs <= r_s1_fs;
            r_out_le <= r_s1_le;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_chan_a_out      = r_out_a;
    assign o_chan_b_out      = r_out_b;
    assign o_chan_c_out      = r_out_c;
    assign o_frame_start_out = r_out_fs;
    assign o_line_end_out    = r_out_le;

    a_empty_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_ready)
        else $error("input stalled with the output register empty");

    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !r_out_valid |=> r_out_valid)
        else $error("beat lost between input and output registers");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s2_load |=> r_s1_valid && $stable(r_s1_a) && $stable(r_s1_le))
        else $error("input register dropped a waiting beat");

endmodule

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import cmc_pkg::*;

    typedef struct {
        t_pix a;
        t_pix b;
        t_pix c;
        logic fs;
        logic le;
    } t_px;

    typedef struct {
        t_cfg cfg;
        t_px  px;
        bit   typed;
        t_pix ea;
        t_pix eb;
        t_pix ec;
    } t_vec;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    t_reg_idx         i_cfg_idx;
    logic [REG_W-1:0] i_cfg_wdata;
    logic             i_valid;
    logic             o_ready;
    t_pix             i_chan_a_in;
    t_pix             i_chan_b_in;
    t_pix             i_chan_c_in;
    logic             i_frame_start_in;
    logic             i_line_end_in;
    logic             o_valid;
    logic             i_ready;
    t_pix             o_chan_a_out;
    t_pix             o_chan_b_out;
    t_pix             o_chan_c_out;
    logic             o_frame_start_out;
    logic             o_line_end_out;

    t_cfg cur_cfg;
    t_px  pending_px[$];
    int   mismatches;
    int   pixels_out;

    color_matrix_convert u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_chan_a_in       (i_chan_a_in),
        .i_chan_b_in       (i_chan_b_in),
        .i_chan_c_in       (i_chan_c_in),
        .i_frame_start_in  (i_frame_start_in),
        .i_line_end_in     (i_line_end_in),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_chan_a_out      (o_chan_a_out),
        .o_chan_b_out      (o_chan_b_out),
        .o_chan_c_out      (o_chan_c_out),
        .o_frame_start_out (o_frame_start_out),
        .o_line_end_out    (o_line_end_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    // one output channel: signed weighted sum in 2^-8 units, round half up, clamp
    function automatic t_pix convert_chan(input logic [REG_W-1:0] weights,
                                          input logic [COEF_W-1:0] offset,
                                          input t_px px);
        int acc;
        int q;
        acc = int'($signed(weights[0 +: COEF_W])) * int'(px.a)
            + int'($signed(weights[COEF_W +: COEF_W])) * int'(px.b)
            + int'($signed(weights[2*COEF_W +: COEF_W])) * int'(px.c)
            + int'($signed(offset)) * 256;
        q = (acc + 128) >>> 8;
        if (q < 0) q = 0;
        if (q > 255) q = 255;
        return t_pix'(q);
    endfunction

    function automatic t_px convert_pixel(input t_px px);
        t_px r;
        r.a  = convert_chan(cur_cfg.row_one, cur_cfg.bias[0 +: COEF_W], px);
        r.b  = convert_chan(cur_cfg.row_two, cur_cfg.bias[COEF_W +: COEF_W], px);
        r.c  = convert_chan(cur_cfg.row_three, cur_cfg.bias[2*COEF_W +: COEF_W], px);
        r.fs = px.fs;
        r.le = px.le;
        return r;
    endfunction

    function automatic logic [REG_W-1:0] pack3(input logic [COEF_W-1:0] f0,
                                               input logic [COEF_W-1:0] f1,
                                               input logic [COEF_W-1:0] f2);
        return {f2, f1, f0};
    endfunction

    function automatic t_cfg uniform_cfg(input logic [COEF_W-1:0] w,
                                         input logic [COEF_W-1:0] b);
        t_cfg c;
        c.row_one   = pack3(w, w, w);
        c.row_two   = pack3(w, w, w);
        c.row_three = pack3(w, w, w);
        c.bias      = pack3(b, b, b);
        return c;
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 10'h1FF;
            1: return 10'h200;
            2: return 10'h100;
            3: return 10'h000;
            default: return COEF_W'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic t_cfg rand_cfg();
        t_cfg c;
        c.row_one   = pack3(rand_coef(), rand_coef(), rand_coef());
        c.row_two   = pack3(rand_coef(), rand_coef(), rand_coef());
        c.row_three = pack3(rand_coef(), rand_coef(), rand_coef());
        c.bias      = pack3(rand_coef(), rand_coef(), rand_coef());
        return c;
    endfunction

    function automatic t_pix rand_pix();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return t_pix'($urandom_range(0, 255));
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    function automatic t_vec mk_vec(input t_cfg cfg, input t_pix a, input t_pix b,
                                    input t_pix c, input logic fs, input logic le,
                                    input bit typed, input t_pix ea, input t_pix eb,
                                    input t_pix ec);
        t_vec v;
        v.cfg   = cfg;
        v.px.a  = a;
        v.px.b  = b;
        v.px.c  = c;
        v.px.fs = fs;
        v.px.le = le;
        v.typed = typed;
        v.ea    = ea;
        v.eb    = eb;
        v.ec    = ec;
        return v;
    endfunction

    task automatic write_reg(input t_reg_idx idx, input logic [REG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
    endtask

    // drain the pipe, then load all four registers
    task automatic apply_cfg(input t_cfg c);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_px.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
        write_reg(REG_ROW_ONE, c.row_one);
        write_reg(REG_ROW_TWO, c.row_two);
        write_reg(REG_ROW_THREE, c.row_three);
        write_reg(REG_BIAS, c.bias);
        cur_cfg = c;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic idle_tx(input int pct);
        int n;
        if ($urandom_range(0, 99) < pct) begin
            n = gap_len();
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_px(input t_px px, input bit typed, input t_pix ea,
                           input t_pix eb, input t_pix ec);
        t_px want;
        @(negedge i_clk);
        i_valid          <= 1'b1;
        i_chan_a_in      <= px.a;
        i_chan_b_in      <= px.b;
        i_chan_c_in      <= px.c;
        i_frame_start_in <= px.fs;
        i_line_end_in    <= px.le;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (typed) begin
            want.a  = ea;
            want.b  = eb;
            want.c  = ec;
            want.fs = px.fs;
            want.le = px.le;
        end else begin
            want = convert_pixel(px);
        end
        pending_px.push_back(want);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_px want;
        if (i_rst_n && o_valid && i_ready) begin
            pixels_out++;
            if (pending_px.size() == 0) begin
                $display("%0t: unexpected output beat, got %0d %0d %0d", $time,
                         o_chan_a_out, o_chan_b_out, o_chan_c_out);
                mismatches++;
            end else begin
                want = pending_px.pop_front();
                check_field("chan_a", want.a, o_chan_a_out);
                check_field("chan_b", want.b, o_chan_b_out);
                check_field("chan_c", want.c, o_chan_c_out);
                check_field("frame_start", want.fs, o_frame_start_out);
                check_field("line_end", want.le, o_line_end_out);
            end
        end
    end

    // receiver: random stalls, quiet stretches and one long hold-off to back up the pipe
    initial begin
        int stall_left;
        int calm_left;
        bit long_hold_done;
        stall_left     = 0;
        calm_left      = 0;
        long_hold_done = 1'b0;
        i_ready        = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else if (!long_hold_done && pixels_out >= 400) begin
                long_hold_done = 1'b1;
                i_ready        <= 1'b0;
                stall_left     = 120;
            end else if (calm_left > 0) begin
                i_ready <= 1'b1;
                calm_left--;
            end else if ($urandom_range(0, 99) < 4) begin
                calm_left = $urandom_range(30, 150);
                i_ready   <= 1'b1;
            end else if ($urandom_range(0, 99) < 25) begin
                stall_left = gap_len() - 1;
                i_ready    <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        t_vec vec_tbl[$];
        t_cfg cfg_zero;
        t_cfg cfg_ident;
        t_cfg cfg_max;
        t_cfg cfg_min;
        t_cfg cfg_half;
        t_cfg cfg_mix;
        t_cfg c;
        t_px  px;
        int   tx_pct;

        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = REG_ROW_ONE;
        i_cfg_wdata      = '0;
        i_valid          = 1'b0;
        i_chan_a_in      = '0;
        i_chan_b_in      = '0;
        i_chan_c_in      = '0;
        i_frame_start_in = 1'b0;
        i_line_end_in    = 1'b0;
        cur_cfg          = '0;
        mismatches       = 0;
        pixels_out       = 0;

        cfg_zero            = '0;
        cfg_ident.row_one   = pack3(10'h100, 10'h000, 10'h000);
        cfg_ident.row_two   = pack3(10'h000, 10'h100, 10'h000);
        cfg_ident.row_three = pack3(10'h000, 10'h000, 10'h100);
        cfg_ident.bias      = '0;
        cfg_max             = uniform_cfg(10'h1FF, 10'h1FF);
        cfg_min             = uniform_cfg(10'h200, 10'h200);
        // smallest positive, smallest negative and one half, all on channel a
        cfg_half.row_one    = pack3(10'h001, 10'h000, 10'h000);
        cfg_half.row_two    = pack3(10'h3FF, 10'h000, 10'h000);
        cfg_half.row_three  = pack3(10'h080, 10'h000, 10'h000);
        cfg_half.bias       = '0;
        cfg_mix.row_one     = pack3(10'h080, 10'h1FF, 10'h3C0);
        cfg_mix.row_two     = pack3(10'h040, 10'h100, 10'h200);
        cfg_mix.row_three   = pack3(10'h1A0, 10'h301, 10'h0FF);
        cfg_mix.bias        = pack3(10'h3F0, 10'h010, 10'h200);

        // registers still at reset: everything comes out zero
        vec_tbl.push_back(mk_vec(cfg_zero, 8'h00, 8'h00, 8'h00, 0, 0, 1, 0, 0, 0));
        vec_tbl.push_back(mk_vec(cfg_zero, 8'hFF, 8'hFF, 8'hFF, 1, 1, 1, 0, 0, 0));
        vec_tbl.push_back(mk_vec(cfg_zero, 8'hAA, 8'h55, 8'h0F, 1, 0, 1, 0, 0, 0));
        vec_tbl.push_back(mk_vec(cfg_ident, 8'h00, 8'h00, 8'h00, 0, 1, 1, 8'h00, 8'h00, 8'h00));
        vec_tbl.push_back(mk_vec(cfg_ident, 8'hFF, 8'hFF, 8'hFF, 1, 1, 1, 8'hFF, 8'hFF, 8'hFF));
        vec_tbl.push_back(mk_vec(cfg_ident, 8'h12, 8'h80, 8'hFE, 0, 0, 1, 8'h12, 8'h80, 8'hFE));
        vec_tbl.push_back(mk_vec(cfg_ident, 8'h55, 8'hAA, 8'h01, 1, 0, 1, 8'h55, 8'hAA, 8'h01));
        // full-scale weights and bias clip high, most negative clip low
        vec_tbl.push_back(mk_vec(cfg_max, 8'h00, 8'h00, 8'h00, 0, 1, 1, 8'hFF, 8'hFF, 8'hFF));
        vec_tbl.push_back(mk_vec(cfg_max, 8'hFF, 8'hFF, 8'hFF, 1, 0, 1, 8'hFF, 8'hFF, 8'hFF));
        vec_tbl.push_back(mk_vec(cfg_min, 8'h00, 8'h00, 8'h00, 1, 1, 1, 8'h00, 8'h00, 8'h00));
        vec_tbl.push_back(mk_vec(cfg_min, 8'hFF, 8'hFF, 8'hFF, 0, 0, 1, 8'h00, 8'h00, 8'h00));
        // exact halves round up, just-below-half rounds down, negative half lands on zero
        vec_tbl.push_back(mk_vec(cfg_half, 8'h80, 8'h00, 8'h00, 0, 0, 1, 8'h01, 8'h00, 8'h40));
        vec_tbl.push_back(mk_vec(cfg_half, 8'h01, 8'h00, 8'h00, 1, 0, 1, 8'h00, 8'h00, 8'h01));
        vec_tbl.push_back(mk_vec(cfg_half, 8'h03, 8'h00, 8'h00, 0, 1, 1, 8'h00, 8'h00, 8'h02));
        vec_tbl.push_back(mk_vec(cfg_half, 8'hFF, 8'h00, 8'h00, 1, 1, 1, 8'h01, 8'h00, 8'h80));
        vec_tbl.push_back(mk_vec(cfg_half, 8'h80, 8'hFF, 8'hFF, 0, 0, 1, 8'h01, 8'h00, 8'h40));
        vec_tbl.push_back(mk_vec(cfg_half, 8'h7F, 8'h00, 8'h00, 0, 0, 0, 0, 0, 0));
        vec_tbl.push_back(mk_vec(cfg_mix, 8'hFF, 8'h00, 8'h80, 1, 0, 0, 0, 0, 0));
        vec_tbl.push_back(mk_vec(cfg_mix, 8'h00, 8'hFF, 8'h40, 0, 1, 0, 0, 0, 0));
        vec_tbl.push_back(mk_vec(cfg_mix, 8'h64, 8'hC8, 8'h32, 1, 1, 0, 0, 0, 0));
        vec_tbl.push_back(mk_vec(cfg_mix, 8'hFF, 8'hFF, 8'hFF, 0, 0, 0, 0, 0, 0));

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (vec_tbl[i]) begin
            if (vec_tbl[i].cfg != cur_cfg) apply_cfg(vec_tbl[i].cfg);
            idle_tx(30);
            send_px(vec_tbl[i].px, vec_tbl[i].typed, vec_tbl[i].ea, vec_tbl[i].eb,
                    vec_tbl[i].ec);
        end

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                2: c = cfg_max;
                3: c = cfg_min;
                4: begin
                    c      = cfg_ident;
                    c.bias = pack3(rand_coef(), rand_coef(), rand_coef());
                end
                6: c = uniform_cfg(10'h200, 10'h1FF);
                default: c = rand_cfg();
            endcase
            apply_cfg(c);
            tx_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 15 : 40);
            for (int n = 0; n < 142; n++) begin
                px.a  = rand_pix();
                px.b  = rand_pix();
                px.c  = rand_pix();
                px.fs = 1'($urandom_range(0, 1));
                px.le = 1'($urandom_range(0, 1));
                idle_tx(tx_pct);
                send_px(px, 0, 0, 0, 0);
            end
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_px.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
